[rtl/ope_pkg.sv]
package ope_pkg;

  localparam int DvdW = 68;
  localparam int DvsW = 34;
  localparam int MaxOrderDef = 31;

  localparam logic signed [63:0] QOne = 64'sh0000_0001_0000_0000;
  localparam logic signed [63:0] SMax = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [63:0] SMin = 64'sh8000_0000_0000_0000;
  localparam logic [63:0] MagLim = 64'h8000_0000_0000_0000;

  localparam logic FamLegendre = 1'b0;
  localparam logic FamHermite = 1'b1;

  localparam logic [1:0] RegFamily = 2'd0;
  localparam logic [1:0] RegFirst = 2'd1;
  localparam logic [1:0] RegSecond = 2'd2;

  typedef struct packed {
    logic signed [63:0] v;
    logic s;
  } sres_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] a);
    mag64 = a[63] ? (~a + 64'd1) : a;
  endfunction

  // signed value from a magnitude, clipping to the 64 bit range
  function automatic sres_t fit(input logic [63:0] m, input logic over, input logic neg);
    sres_t r;
    r.s = 1'b0;
    r.v = '0;
    if (over) begin
      r.s = 1'b1;
      r.v = neg ? SMin : SMax;
    end else if (neg) begin
      if (m > MagLim) begin
        r.s = 1'b1;
        r.v = SMin;
      end else begin
        r.v = $signed(~m + 64'd1);
      end
    end else if (m[63]) begin
      r.s = 1'b1;
      r.v = SMax;
    end else begin
      r.v = $signed(m);
    end
    return r;
  endfunction

  function automatic sres_t sat_sub(input logic signed [63:0] a, input logic signed [63:0] b);
    logic signed [64:0] d;
    sres_t r;
    d = 65'(a) - 65'(b);
    r.s = d[64] != d[63];
    r.v = r.s ? (d[64] ? SMin : SMax) : d[63:0];
    return r;
  endfunction

endpackage

[rtl/ope_mul.sv]
module ope_mul (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic         done,
  output logic [127:0] prod
);
  import ope_pkg::*;

  logic [1:0]   cnt_r, cnt_nxt;
  logic         busy_r, busy_nxt;
  logic         done_r, done_nxt;
  logic [63:0]  a_r, a_nxt, b_r, b_nxt;
  logic [127:0] acc_r, acc_nxt;
  logic [31:0]  ah, bh;
  logic [63:0]  pp;
  logic [6:0]   sh;

  // one 32x32 partial product per cycle
  always_comb begin
    ah = cnt_r[1] ? a_r[63:32] : a_r[31:0];
    bh = cnt_r[0] ? b_r[63:32] : b_r[31:0];
    pp = 64'(ah) * 64'(bh);
    sh = 7'(({1'b0, cnt_r[1]} + {1'b0, cnt_r[0]})) << 5;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    a_nxt = a_r;
    b_nxt = b_r;
    acc_nxt = acc_r;
    if (start) begin
      a_nxt = a;
      b_nxt = b;
      acc_nxt = '0;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = acc_r + (128'(pp) << sh);
      cnt_nxt = cnt_r + 2'd1;
      if (cnt_r == 2'd3) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    a_r <= a_nxt;
    b_r <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy_r)
    else $error("multiplier restarted while busy");
  a_done_once: assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("multiplier done while busy");
  a_four: assert property (@(posedge clk) disable iff (!rst_n) start |=> ##3 busy_r)
    else $error("multiplier finished early");
`endif

endmodule

[rtl/ope_div.sv]
module ope_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ope_pkg::DvdW-1:0]   dvd,
  input  logic [ope_pkg::DvsW-1:0]   dvs,
  output logic                       done,
  output logic [ope_pkg::DvdW-1:0]   quo
);
  import ope_pkg::*;

  localparam int CntW = $clog2(DvdW + 1);

  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [DvdW-1:0] dvd_r, dvd_nxt, q_r, q_nxt;
  logic [DvsW-1:0] dvs_r, dvs_nxt, rem_r, rem_nxt;
  logic [DvsW:0]   trial, diff;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial = {rem_r, dvd_r[DvdW-1]};
    diff = trial - {1'b0, dvs_r};
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    dvd_nxt = dvd_r;
    dvs_nxt = dvs_r;
    q_nxt = q_r;
    rem_nxt = rem_r;
    if (start) begin
      dvd_nxt = dvd;
      dvs_nxt = dvs;
      q_nxt = '0;
      rem_nxt = '0;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = dvd_r << 1;
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[DvsW-1:0];
        q_nxt = {q_r[DvdW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DvsW-1:0];
        q_nxt = {q_r[DvdW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CntW'(DvdW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    q_r <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quo = q_r;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy_r)
    else $error("divider restarted while busy");
  a_rem_lt: assert property (@(posedge clk) disable iff (!rst_n)
      busy_r && $past(busy_r) |-> rem_r < dvs_r || dvs_r == '0)
    else $error("divider remainder out of range");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("divider done while busy");
`endif

endmodule

[rtl/orthogonal_polynomial_evaluator.sv]
// the radix-2 divider scales the point (skipped when out of range or the divisor is zero), then each step
// above degree one runs on the 32x32 multiplier and the divider for Legendre, on the multiplier alone
// for Hermite or on both for normalized Hermite, followed by the Legendre normalization multiply
// and the write of the result into the output register
// one item at a time; a new request is taken once the previous result sits in the output reg
// synchronous active-low reset: family Legendre, bounds -1.0 and +1.0, no result pending
module orthogonal_polynomial_evaluator #(
  parameter int DEG_LIMIT = ope_pkg::MaxOrderDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // degree[4:0], point[36:5], normalize[37]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // value[63:0]
  output logic [1:0]  out_tuser,  // range_error[0], saturated[1]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import ope_pkg::*;

  localparam int KW = $clog2(DEG_LIMIT + 2);

  typedef enum logic [3:0] {
    S_IDLE, S_XDIV, S_STEP, S_QMUL, S_SCA, S_SCB, S_KDIV, S_NORM, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic go_r, go_nxt;
  logic fam_r, fam_nxt;
  logic signed [31:0] first_r, first_nxt, second_r, second_nxt, x_r, x_nxt;
  logic [KW-1:0] n_r, n_nxt, k_r, k_nxt;
  logic norm_r, norm_nxt, sat_r, sat_nxt, rerr_r, rerr_nxt;
  logic signed [63:0] xr_r, xr_nxt, p0_r, p0_nxt, p1_r, p1_nxt, t_r, t_nxt, res_r, res_nxt;
  logic dneg_r, dneg_nxt;
  logic ov_r, ov_nxt;
  logic [63:0] od_r, od_nxt;
  logic [1:0] ou_r, ou_nxt;

  logic mul_start, mul_done, div_start, div_done;
  logic [63:0] mul_a, mul_b;
  logic [127:0] prod;
  logic [DvdW-1:0] div_dvd, quo;
  logic [DvsW-1:0] div_dvs;

  logic signed [34:0] num;
  logic signed [33:0] den;
  logic [34:0] num_m;
  logic [33:0] den_m;
  logic out_rng;
  logic signed [63:0] fin;
  logic [KW:0] k2m1, n2p1;
  sres_t qm, sc, sb, ds, dq;

  ope_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(prod)
  );

  ope_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dvd(div_dvd), .dvs(div_dvs),
    .done(div_done), .quo(quo)
  );

  always_comb begin
    if (fam_r == FamLegendre) begin
      num = (35'(x_r) <<< 1) - 35'(first_r) - 35'(second_r);
      den = 34'(second_r) - 34'(first_r);
    end else begin
      num = 35'(x_r) - 35'(first_r);
      den = 34'(second_r);
    end
    num_m = num[34] ? (~num + 35'd1) : num;
    den_m = den[33] ? (~den + 34'd1) : den;
    out_rng = (fam_r == FamLegendre) && ((x_r < first_r) || (x_r > second_r));
    k2m1 = {k_r, 1'b0} - (KW+1)'(1);
    n2p1 = {n_r, 1'b0} + (KW+1)'(1);
    fin = (n_r == '0) ? QOne : p1_r;
  end

  // shared unit operands
  always_comb begin
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_a = mag64(xr_r);
    mul_b = mag64(p1_r);
    div_dvd = {1'b0, num_m, 32'd0};
    div_dvs = den_m;
    case (state_r)
      S_XDIV: div_start = !go_r && !out_rng && (den_m != '0);
      S_QMUL: mul_start = !go_r;
      S_SCA: begin
        mul_start = !go_r;
        mul_a = mag64(t_r);
        mul_b = 64'(k2m1);
      end
      S_SCB: begin
        mul_start = !go_r;
        mul_a = mag64(p0_r);
        mul_b = 64'(k_r - KW'(1));
      end
      S_KDIV: begin
        div_start = !go_r;
        div_dvd = DvdW'(mag64(t_r));
        div_dvs = DvsW'(k_r);
      end
      S_NORM: begin
        mul_start = !go_r;
        mul_a = mag64(fin);
        mul_b = 64'(n2p1);
      end
      default: ;
    endcase
  end

  always_comb begin
    qm = fit(prod[95:32], prod[127:96] != '0, xr_r[63] ^ p1_r[63]);
    sc = fit(prod[63:0], prod[127:64] != '0, t_r[63]);
    sb = fit(prod[63:0], prod[127:64] != '0, p0_r[63]);
    ds = sat_sub(t_r, sb.v);
    dq = sat_sub(qm.v, p0_r);
  end

  always_comb begin
    state_nxt = state_r;
    go_nxt = go_r;
    fam_nxt = fam_r;
    first_nxt = first_r;
    second_nxt = second_r;
    x_nxt = x_r;
    n_nxt = n_r;
    k_nxt = k_r;
    norm_nxt = norm_r;
    sat_nxt = sat_r;
    rerr_nxt = rerr_r;
    xr_nxt = xr_r;
    p0_nxt = p0_r;
    p1_nxt = p1_r;
    t_nxt = t_r;
    res_nxt = res_r;
    dneg_nxt = dneg_r;
    ov_nxt = ov_r;
    od_nxt = od_r;
    ou_nxt = ou_r;

    if (ov_r && out_tready) ov_nxt = 1'b0;

    if (cfg_valid) begin
      case (cfg_index)
        RegFamily: fam_nxt = cfg_data[0];
        RegFirst: first_nxt = cfg_data;
        RegSecond: second_nxt = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          n_nxt = (32'(in_tdata[4:0]) > DEG_LIMIT) ? KW'(DEG_LIMIT) : KW'(in_tdata[4:0]);
          x_nxt = in_tdata[36:5];
          norm_nxt = in_tdata[37];
          sat_nxt = 1'b0;
          rerr_nxt = 1'b0;
          go_nxt = 1'b0;
          state_nxt = S_XDIV;
        end
      end
      S_XDIV: begin
        p0_nxt = QOne;
        k_nxt = KW'(2);
        if (!go_r) begin
          if (out_rng) begin
            rerr_nxt = 1'b1;
            res_nxt = '0;
            state_nxt = S_OUT;
          end else if (den_m == '0) begin
            if (num_m == '0) begin
              xr_nxt = '0;
            end else begin
              sat_nxt = 1'b1;
              xr_nxt = num[34] ? SMin : SMax;
            end
            p1_nxt = xr_nxt;
            state_nxt = S_STEP;
          end else begin
            go_nxt = 1'b1;
          end
        end else if (div_done) begin
          go_nxt = 1'b0;
          xr_nxt = fit(quo[63:0], quo[DvdW-1:64] != '0, num[34] ^ den[33]).v;
          sat_nxt = sat_r | fit(quo[63:0], quo[DvdW-1:64] != '0, num[34] ^ den[33]).s;
          p1_nxt = xr_nxt;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        if (k_r > n_r) begin
          res_nxt = fin;
          state_nxt = (fam_r == FamLegendre && norm_r) ? S_NORM : S_OUT;
        end else begin
          state_nxt = S_QMUL;
        end
      end
      S_QMUL: begin
        if (!go_r) begin
          go_nxt = 1'b1;
        end else if (mul_done) begin
          go_nxt = 1'b0;
          t_nxt = qm.v;
          sat_nxt = sat_r | qm.s;
          if (fam_r == FamLegendre) begin
            state_nxt = S_SCA;
          end else if (norm_r) begin
            t_nxt = dq.v;
            sat_nxt = sat_r | qm.s | dq.s;
            state_nxt = S_KDIV;
          end else begin
            state_nxt = S_SCB;
          end
        end
      end
      S_SCA: begin
        if (!go_r) begin
          go_nxt = 1'b1;
        end else if (mul_done) begin
          go_nxt = 1'b0;
          t_nxt = sc.v;
          sat_nxt = sat_r | sc.s;
          state_nxt = S_SCB;
        end
      end
      S_SCB: begin
        if (!go_r) begin
          go_nxt = 1'b1;
        end else if (mul_done) begin
          go_nxt = 1'b0;
          sat_nxt = sat_r | sb.s | ds.s;
          if (fam_r == FamLegendre) begin
            t_nxt = ds.v;
            state_nxt = S_KDIV;
          end else begin
            p0_nxt = p1_r;
            p1_nxt = ds.v;
            k_nxt = k_r + KW'(1);
            state_nxt = S_STEP;
          end
        end
      end
      S_KDIV: begin
        if (!go_r) begin
          go_nxt = 1'b1;
          dneg_nxt = t_r[63];
        end else if (div_done) begin
          go_nxt = 1'b0;
          p0_nxt = p1_r;
          p1_nxt = dneg_r ? -$signed(quo[63:0]) : $signed(quo[63:0]);
          k_nxt = k_r + KW'(1);
          state_nxt = S_STEP;
        end
      end
      S_NORM: begin
        if (!go_r) begin
          go_nxt = 1'b1;
          t_nxt = fin;
        end else if (mul_done) begin
          go_nxt = 1'b0;
          res_nxt = sc.v;
          sat_nxt = sat_r | sc.s;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1;
          od_nxt = res_r;
          ou_nxt = {sat_r, rerr_r};
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      go_r <= 1'b0;
      fam_r <= FamLegendre;
      first_r <= -32'sd65536;
      second_r <= 32'sd65536;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      go_r <= go_nxt;
      fam_r <= fam_nxt;
      first_r <= first_nxt;
      second_r <= second_nxt;
      ov_r <= ov_nxt;
    end
    x_r <= x_nxt;
    n_r <= n_nxt;
    k_r <= k_nxt;
    norm_r <= norm_nxt;
    sat_r <= sat_nxt;
    rerr_r <= rerr_nxt;
    xr_r <= xr_nxt;
    p0_r <= p0_nxt;
    p1_r <= p1_nxt;
    t_r <= t_nxt;
    res_r <= res_nxt;
    dneg_r <= dneg_nxt;
    od_r <= od_nxt;
    ou_r <= ou_nxt;
  end

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_tvalid = ov_r;
  assign out_tdata = od_r;
  assign out_tuser = ou_r;

`ifndef SYNTHESIS
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
      in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while busy");
  a_rerr_zero: assert property (@(posedge clk) disable iff (!rst_n)
      out_tvalid && out_tuser[0] |-> out_tdata == '0 && !out_tuser[1])
    else $error("range error with nonzero value");
  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n) !(mul_start && div_start))
    else $error("both units started together");
`endif

endmodule
